/* sv/tba_pkg.sv */
// Package: shared constants, command codes and queue word type for the time binned accumulator.
`timescale 1ns / 1ps

package tba_pkg;

	localparam int NumBins    = 16;
	localparam int QueueDepth = 8;
	localparam int TimeW      = 32;
	localparam int ValueW     = 16;
	localparam int RidxW      = 4;
	localparam int CmdW       = 2;
	localparam int MaxBinsW   = 7;

	localparam logic [TimeW-1:0] PeriodReset = 32'd60;

	localparam logic [CmdW-1:0] CmdAdd   = 2'd0;
	localparam logic [CmdW-1:0] CmdStart = 2'd1;
	localparam logic [CmdW-1:0] CmdRead  = 2'd2;

	typedef struct packed {
		logic [CmdW-1:0]   cmd;
		logic [ValueW-1:0] value;
		logic [RidxW-1:0]  ridx;
		logic              clear;
		logic              found;
		logic              expired;
		logic [TimeW-1:0]  block_end;
	} item_t;

endpackage

/* sv/time_binned_accumulator_core.sv */
// Top level of the time binned accumulator: front, queue and back.
//
// Input channel (in_valid/in_stall) takes one command word per cycle: add a
// sample into the bin whose window holds its time, start a session and clear
// the bins, or read one bin. Output channel (out_valid/out_stall) returns one
// result word per command, in order. The bin_period register is written over
// cfg_valid/cfg_ready, which is always ready; write it only while idle.
// A word passes the front stages, the queue, the back and the output register.
// Throughput is one word per cycle: the front runs three stages (session
// start, window bounds, compare and pick), the back does one bin memory
// read-modify-write per cycle with forwarding between neighboring words.
// When the receiver stalls, the output register holds, the back halts and the
// queue fills; in_stall rises once the queue plus words in the front reach the
// queue depth. Reset sets bin_period to 60, the session start to zero and
// every bin to zero through per-bin valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module time_binned_accumulator_core #(
	parameter int NUM_BINS    = tba_pkg::NumBins,
	parameter int QUEUE_DEPTH = tba_pkg::QueueDepth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tba_pkg::CmdW-1:0]   cmd,
	input  logic [tba_pkg::TimeW-1:0]  sample_time,
	input  logic [tba_pkg::ValueW-1:0] sample_value,
	input  logic [tba_pkg::RidxW-1:0]  read_index,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tba_pkg::TimeW-1:0]  bin_period,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       accepted,
	output logic [tba_pkg::ValueW-1:0] bin_value,
	output logic                       expired,
	output logic [tba_pkg::TimeW-1:0]  block_end
);

	localparam int IdxW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int LvlW   = $clog2(QUEUE_DEPTH + 1);
	localparam int ItemW  = $bits(tba_pkg::item_t);
	localparam int WordW  = ItemW + IdxW;

	logic                 q_push;
	logic                 q_pop;
	logic                 q_nonempty;
	logic [LvlW-1:0]      q_level;
	tba_pkg::item_t       push_item;
	logic [IdxW-1:0]      push_idx;
	logic [WordW-1:0]     push_word;
	logic [WordW-1:0]     pop_word;
	tba_pkg::item_t       pop_item;
	logic [IdxW-1:0]      pop_idx;

	tba_front #(
		.NUM_BINS    (NUM_BINS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.IDX_W       (IdxW),
		.LVL_W       (LvlW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.sample_time  (sample_time),
		.sample_value (sample_value),
		.read_index   (read_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.bin_period   (bin_period),
		.q_level      (q_level),
		.q_push       (q_push),
		.q_item       (push_item),
		.q_idx        (push_idx)
	);

	assign push_word = {push_item, push_idx};

	tba_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (WordW),
		.LVL_W (LvlW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.din      (push_word),
		.pop      (q_pop),
		.dout     (pop_word),
		.nonempty (q_nonempty),
		.level    (q_level)
	);

	assign pop_item = pop_word[WordW-1:IdxW];
	assign pop_idx  = pop_word[IdxW-1:0];

	tba_back #(
		.NUM_BINS (NUM_BINS),
		.IDX_W    (IdxW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_nonempty),
		.q_item    (pop_item),
		.q_idx     (pop_idx),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.bin_value (bin_value),
		.expired   (expired),
		.block_end (block_end)
	);

endmodule

/* sv/tba_fifo.sv */
// Queue between the classifying front and the bin update back.
`timescale 1ns / 1ps

module tba_fifo #(
	parameter int DEPTH = tba_pkg::QueueDepth,
	parameter int WIDTH = $bits(tba_pkg::item_t),
	parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int LVL_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             nonempty,
	output logic [LVL_W-1:0] level
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	assign dout     = slot_q[rd_ptr_q];
	assign nonempty = (level_q != '0);
	assign level    = level_q;

endmodule

/* sv/tba_front.sv */
// Front: accepts words, tracks the session start and classifies each time against the bins.
`timescale 1ns / 1ps

module tba_front #(
	parameter int NUM_BINS    = tba_pkg::NumBins,
	parameter int QUEUE_DEPTH = tba_pkg::QueueDepth,
	parameter int IDX_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
	parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tba_pkg::CmdW-1:0]     cmd,
	input  logic [tba_pkg::TimeW-1:0]    sample_time,
	input  logic [tba_pkg::ValueW-1:0]   sample_value,
	input  logic [tba_pkg::RidxW-1:0]    read_index,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tba_pkg::TimeW-1:0]    bin_period,
	input  logic [LVL_W-1:0]             q_level,
	output logic                         q_push,
	output tba_pkg::item_t               q_item,
	output logic [IDX_W-1:0]             q_idx
);

	logic [tba_pkg::TimeW-1:0]  off_q [NUM_BINS+1];
	logic [tba_pkg::TimeW-1:0]  start_q;
	logic                       take;
	logic                       restart;
	logic [LVL_W:0]             occupancy;

	logic                       v_s1, v_s2, v_s3;
	logic [tba_pkg::CmdW-1:0]   cmd_s1, cmd_s2, cmd_s3;
	logic [tba_pkg::TimeW-1:0]  time_s1, time_s2;
	logic [tba_pkg::ValueW-1:0] value_s1, value_s2, value_s3;
	logic [tba_pkg::RidxW-1:0]  ridx_s1, ridx_s2, ridx_s3;
	logic                       clear_s1, clear_s2, clear_s3;
	logic [tba_pkg::TimeW-1:0]  start_s1;
	logic [tba_pkg::TimeW-1:0]  lo_s2 [NUM_BINS+1];
	logic                       found_s3, expired_s3;
	logic [IDX_W-1:0]           idx_s3;
	logic [tba_pkg::TimeW-1:0]  end_s3;

	logic [NUM_BINS-1:0]        match;
	logic [NUM_BINS-1:0]        first;
	logic [tba_pkg::TimeW-1:0]  end_sel;
	logic [IDX_W-1:0]           idx_sel;

	assign cfg_ready = 1'b1;
	assign take      = in_valid && !in_stall;
	assign restart   = ((cmd == tba_pkg::CmdAdd) && (start_q == '0)) ||
		(cmd == tba_pkg::CmdStart);
	assign occupancy = {1'b0, q_level} + (LVL_W+1)'(v_s1) + (LVL_W+1)'(v_s2) +
		(LVL_W+1)'(v_s3);
	assign in_stall  = (occupancy >= (LVL_W+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NUM_BINS; i++) begin
				off_q[i] <= tba_pkg::TimeW'(i) * tba_pkg::PeriodReset;
			end
		end else if (cfg_valid) begin
			for (int i = 0; i <= NUM_BINS; i++) begin
				off_q[i] <= tba_pkg::TimeW'(i) * bin_period;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			if (take && restart) begin
				start_q <= sample_time;
			end
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1   <= cmd;
			time_s1  <= sample_time;
			value_s1 <= sample_value;
			ridx_s1  <= read_index;
			clear_s1 <= restart;
			start_s1 <= restart ? sample_time : start_q;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2   <= cmd_s1;
		time_s2  <= time_s1;
		value_s2 <= value_s1;
		ridx_s2  <= ridx_s1;
		clear_s2 <= clear_s1;
		for (int i = 0; i <= NUM_BINS; i++) begin
			lo_s2[i] <= start_s1 + off_q[i];
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_BINS; i++) begin
			match[i] = (time_s2 >= lo_s2[i]) && (time_s2 < lo_s2[i+1]);
		end
		first   = match & (~match + 1'b1);
		end_sel = '0;
		idx_sel = '0;
		for (int i = 0; i < NUM_BINS; i++) begin
			end_sel = end_sel | ({tba_pkg::TimeW{first[i]}} & lo_s2[i+1]);
			idx_sel = idx_sel | ({IDX_W{first[i]}} & IDX_W'(i));
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3     <= cmd_s2;
		value_s3   <= value_s2;
		ridx_s3    <= ridx_s2;
		clear_s3   <= clear_s2;
		found_s3   <= |match;
		idx_s3     <= idx_sel;
		end_s3     <= (|match) ? end_sel : lo_s2[NUM_BINS];
		expired_s3 <= (time_s2 >= lo_s2[NUM_BINS]);
	end

	assign q_push           = v_s3;
	assign q_item.cmd       = cmd_s3;
	assign q_item.value     = value_s3;
	assign q_item.ridx      = ridx_s3;
	assign q_item.clear     = clear_s3;
	assign q_item.found     = found_s3;
	assign q_item.expired   = expired_s3;
	assign q_item.block_end = end_s3;
	assign q_idx            = idx_s3;

endmodule

/* sv/tba_back.sv */
// Back: bin memory read-modify-write, clearing and the output register.
`timescale 1ns / 1ps

module tba_back #(
	parameter int NUM_BINS = tba_pkg::NumBins,
	parameter int IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  tba_pkg::item_t             q_item,
	input  logic [IDX_W-1:0]           q_idx,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       accepted,
	output logic [tba_pkg::ValueW-1:0] bin_value,
	output logic                       expired,
	output logic [tba_pkg::TimeW-1:0]  block_end
);

	logic [tba_pkg::ValueW-1:0]   bin_q [NUM_BINS];
	logic [NUM_BINS-1:0]          vld_q;
	logic [NUM_BINS-1:0]          vld_d;

	logic [tba_pkg::MaxBinsW-1:0] ridx_w;
	logic                         rd_ok;
	logic [IDX_W-1:0]             addr_pop;

	logic                         v_b1;
	tba_pkg::item_t               item_b1;
	logic [IDX_W-1:0]             addr_b1;
	logic                         rd_ok_b1;
	logic [tba_pkg::ValueW-1:0]   rd_b1;
	logic                         vld_b1;
	logic                         byp_b1;
	logic [tba_pkg::ValueW-1:0]   byp_data_b1;

	logic                         adv_b1;
	logic                         wr;
	logic [tba_pkg::ValueW-1:0]   old;
	logic [tba_pkg::ValueW-1:0]   sum;

	logic                         out_valid_q;
	logic                         accepted_q;
	logic [tba_pkg::ValueW-1:0]   bin_value_q;
	logic                         expired_q;
	logic [tba_pkg::TimeW-1:0]    block_end_q;

	assign ridx_w   = tba_pkg::MaxBinsW'(q_item.ridx);
	assign rd_ok    = (ridx_w < tba_pkg::MaxBinsW'(NUM_BINS));
	assign addr_pop = (q_item.cmd == tba_pkg::CmdRead) ? ridx_w[IDX_W-1:0] : q_idx;

	assign adv_b1 = v_b1 && (!out_valid_q || !out_stall);
	assign q_pop  = q_valid && (!v_b1 || adv_b1);
	assign wr     = v_b1 && (item_b1.cmd == tba_pkg::CmdAdd) && item_b1.found;

	always_comb begin
		if (item_b1.clear) begin
			old = '0;
		end else if (byp_b1) begin
			old = byp_data_b1;
		end else if (vld_b1) begin
			old = rd_b1;
		end else begin
			old = '0;
		end
		sum = old + item_b1.value;
	end

	always_comb begin
		vld_d = vld_q;
		if (adv_b1) begin
			if (item_b1.clear) begin
				vld_d = '0;
			end
			if (wr) begin
				vld_d[addr_b1] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			v_b1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
			if (q_pop) begin
				v_b1 <= 1'b1;
			end else if (adv_b1) begin
				v_b1 <= 1'b0;
			end
			if (adv_b1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_b1 && wr) begin
			bin_q[addr_b1] <= sum;
		end
		if (q_pop) begin
			rd_b1       <= bin_q[addr_pop];
			vld_b1      <= vld_d[addr_pop];
			byp_b1      <= adv_b1 && wr && (addr_b1 == addr_pop);
			byp_data_b1 <= sum;
			item_b1     <= q_item;
			addr_b1     <= addr_pop;
			rd_ok_b1    <= rd_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_b1) begin
			accepted_q  <= wr;
			bin_value_q <= ((item_b1.cmd == tba_pkg::CmdRead) && rd_ok_b1) ? old : '0;
			expired_q   <= item_b1.expired;
			block_end_q <= item_b1.block_end;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign bin_value = bin_value_q;
	assign expired   = expired_q;
	assign block_end = block_end_q;

endmodule

/* sv/tba_checker.sv */
// Port checker for the time binned accumulator, bound to the top level.
`timescale 1ns / 1ps

module tba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       accepted,
	input logic [tba_pkg::ValueW-1:0] bin_value,
	input logic                       expired,
	input logic [tba_pkg::TimeW-1:0]  block_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(block_end) && $stable(bin_value) &&
			$stable(accepted) && $stable(expired))
		else $error("stalled result word changed");

	a_add_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> bin_value == '0)
		else $error("accepted add carries a bin value");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake output unknown out of reset");

endmodule

bind time_binned_accumulator_core tba_checker u_tba_checker (.*);
